>>> design/sha256c_pkg.sv
// Package for the SHA-256 compression block: widths, item types and round constants.
// Depends on nothing; every design file imports it.
package sha256c_pkg;

    localparam int WORD_W = 32;
    localparam int ROUNDS = 64;
    localparam int ROUND_W = 6;
    localparam int FIFO_DEPTH_DEF = 2;

    typedef logic [WORD_W-1:0] t_word;

    // One input item as it travels from the front part to the round engine.
    typedef struct packed {
        t_word [7:0]  chain;
        t_word [15:0] msg;
    } t_job;

    // Round constants, one per round.
    function automatic t_word round_const(input logic [ROUND_W-1:0] idx);
        t_word k;
        begin
            unique case (idx)
                6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
                6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
                6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
                6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
                6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
                6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
                6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
                6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
                6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
                6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
                6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
                6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
                6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
                6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
                6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
                6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
                6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
                6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
                6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
                6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
                6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
                6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
                6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
                6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
                6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
                6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
                6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
                6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
                6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
                6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
                6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
                6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
                default: k = '0;
            endcase
            return k;
        end
    endfunction

    function automatic t_word rotr(input t_word x, input int n);
        return (x >> n) | (x << (WORD_W - n));
    endfunction

endpackage

>>> design/sha256c_front.sv
// Front part: accepts input items and holds them in a short queue for the round engine.
// Depends on sha256c_pkg.
module sha256c_front import sha256c_pkg::*; #(
    parameter int DEPTH = FIFO_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    output logic o_full,
    input  t_job i_job,
    output logic o_valid,
    input  logic i_take,
    output t_job o_job
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_job               r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr, r_rd;
    logic [PTR_W:0]     r_cnt;
    logic               w_wr_en, w_rd_en;

    assign o_full  = (r_cnt == (PTR_W+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];
    assign w_wr_en = i_push && !o_full;
    assign w_rd_en = i_take && o_valid;

    // Queue storage; entries need no reset.
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_wr] <= i_job;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr_en) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_rd_en) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (PTR_W+1)'(w_wr_en) - (PTR_W+1)'(w_rd_en);
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (PTR_W+1)'(DEPTH)) else $error("queue count overflow");
    a_no_over: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full && !w_rd_en |=> o_full) else $error("full dropped without a read");
    a_stay_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid && !w_wr_en |=> !o_valid) else $error("request appeared without a write");
endmodule

>>> design/sha256c_engine.sv
// Back part: runs 64 SHA-256 rounds, one a cycle, with a rolling 16-word schedule.
// Depends on sha256c_pkg.
module sha256c_engine import sha256c_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_take,
    input  t_job      i_job,
    output logic      o_empty,
    input  logic      i_pop,
    output t_word [7:0] o_chain
);
    typedef enum logic [1:0] {S_IDLE, S_RUN, S_DONE} t_state;

    t_state             r_state;
    logic [ROUND_W-1:0] r_round;
    t_word [7:0]        r_chain, r_v;
    t_word [15:0]       r_w;
    t_word [7:0]        r_res;
    logic               r_res_valid;

    t_word w_big1, w_big0, w_ch, w_maj, w_t1, w_t2, w_s0, w_s1, w_wnew;
    t_word [7:0] w_sum;
    logic w_out_free;

    // Round datapath: state word 0 is a, state word 7 is h.
    always_comb begin
        w_big1 = rotr(r_v[4], 6) ^ rotr(r_v[4], 11) ^ rotr(r_v[4], 25);
        w_ch   = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        w_t1   = r_v[7] + w_big1 + w_ch + round_const(r_round) + r_w[0];
        w_big0 = rotr(r_v[0], 2) ^ rotr(r_v[0], 13) ^ rotr(r_v[0], 22);
        w_maj  = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        w_t2   = w_big0 + w_maj;
        w_s0   = rotr(r_w[1], 7) ^ rotr(r_w[1], 18) ^ (r_w[1] >> 3);
        w_s1   = rotr(r_w[14], 17) ^ rotr(r_w[14], 19) ^ (r_w[14] >> 10);
        w_wnew = r_w[0] + r_w[9] + w_s0 + w_s1;
        for (int i = 0; i < 8; i++) begin
            w_sum[i] = r_v[i] + r_chain[i];
        end
    end

    assign w_out_free = !r_res_valid || i_pop;
    assign o_take     = (r_state == S_IDLE) && i_valid;
    assign o_empty    = !r_res_valid;
    assign o_chain    = r_res;

    // Sequencer, working registers and result register.
    // The incoming item and the result keep word 0 at index 7; the working
    // state keeps word 0 at index 0.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_round     <= '0;
            r_res_valid <= 1'b0;
        end else begin
            if (i_pop && r_res_valid && r_state != S_DONE) begin
                r_res_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        for (int i = 0; i < 8; i++) begin
                            r_chain[i] <= i_job.chain[7 - i];
                            r_v[i]     <= i_job.chain[7 - i];
                        end
                        for (int i = 0; i < 16; i++) begin
                            r_w[i] <= i_job.msg[15 - i];
                        end
                        r_round <= '0;
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    r_v[7] <= r_v[6];
                    r_v[6] <= r_v[5];
                    r_v[5] <= r_v[4];
                    r_v[4] <= r_v[3] + w_t1;
                    r_v[3] <= r_v[2];
                    r_v[2] <= r_v[1];
                    r_v[1] <= r_v[0];
                    r_v[0] <= w_t1 + w_t2;
                    for (int i = 0; i < 15; i++) begin
                        r_w[i] <= r_w[i + 1];
                    end
                    r_w[15] <= w_wnew;
                    r_round <= r_round + 1'b1;
                    if (r_round == ROUND_W'(ROUNDS - 1)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        for (int i = 0; i < 8; i++) begin
                            r_res[7 - i] <= w_sum[i];
                        end
                        r_res_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take |=> r_state == S_RUN && r_round == '0) else $error("bad start");
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid && !i_pop |=> r_res_valid && $stable(r_res)) else $error("result lost");
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_RUN && r_round == ROUND_W'(ROUNDS - 1) |=> r_state == S_DONE)
        else $error("round count slip");
endmodule

>>> design/sha256_compression_block.sv
// SHA-256 compression block: one compression of a chaining value and a message block.
// From accept, the engine loads the item, runs the 64 rounds and, once the result register is free, writes the result.
// The engine takes a new item only after it has written the last result; the queue holds further items meanwhile.
// An input queue (two entries by default) and an output register let both sides stall independently.
// Reset is synchronous and active low; it empties the queue and the result register.
module sha256_compression_block import sha256c_pkg::*; #(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [63:0] i_chain_words_01,
    input  logic [63:0] i_chain_words_23,
    input  logic [63:0] i_chain_words_45,
    input  logic [63:0] i_chain_words_67,
    input  logic [63:0] i_msg_words_01,
    input  logic [63:0] i_msg_words_23,
    input  logic [63:0] i_msg_words_45,
    input  logic [63:0] i_msg_words_67,
    input  logic [63:0] i_msg_words_89,
    input  logic [63:0] i_msg_words_1011,
    input  logic [63:0] i_msg_words_1213,
    input  logic [63:0] i_msg_words_1415,
    output logic        empty,
    input  logic        pop,
    output logic [63:0] o_new_chain_01,
    output logic [63:0] o_new_chain_23,
    output logic [63:0] o_new_chain_45,
    output logic [63:0] o_new_chain_67
);
    t_job        w_in_job, w_q_job;
    logic        w_q_valid, w_take;
    t_word [7:0] w_chain;

    // Unpack words; index 7 of the packed array is word 0.
    assign w_in_job.chain = {i_chain_words_01, i_chain_words_23,
                             i_chain_words_45, i_chain_words_67};
    assign w_in_job.msg   = {i_msg_words_01, i_msg_words_23, i_msg_words_45,
                             i_msg_words_67, i_msg_words_89, i_msg_words_1011,
                             i_msg_words_1213, i_msg_words_1415};

    sha256c_front #(.DEPTH(FIFO_DEPTH)) u_front (
        .i_clk, .i_rst_n, .i_push(push), .o_full(full), .i_job(w_in_job),
        .o_valid(w_q_valid), .i_take(w_take), .o_job(w_q_job)
    );

    sha256c_engine u_engine (
        .i_clk, .i_rst_n, .i_valid(w_q_valid), .o_take(w_take), .i_job(w_q_job),
        .o_empty(empty), .i_pop(pop), .o_chain(w_chain)
    );

    assign {o_new_chain_01, o_new_chain_23, o_new_chain_45, o_new_chain_67} = w_chain;
endmodule
